FILE: src/bcr_pkg.sv
// Shared types and constants of the button click recorder.
package bcr_pkg;

   // Operation codes of a request word.
   typedef enum logic [1:0] {
      OP_LEVEL   = 2'd0,
      OP_POP     = 2'd1,
      OP_CONFIRM = 2'd2,
      OP_WIPE    = 2'd3
   } op_type;

   // Classification codes of a popped click.
   localparam logic [1:0] CLASS_NONE   = 2'd0;
   localparam logic [1:0] CLASS_CLICK  = 2'd1;
   localparam logic [1:0] CLASS_SIMUL  = 2'd2;
   localparam logic [1:0] CLASS_IGNORE = 2'd3;

   // Register indexes of the control port.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_CLICK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIM_WINDOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIM_RESP   = 2'd2;

   // Reset values of the control registers.
   localparam logic [15:0] LONG_CLICK_RST = 16'd1000;
   localparam logic [15:0] SIM_WINDOW_RST = 16'd100;

   // Request word.
   typedef struct packed {
      logic [1:0]  opcode;
      logic        level;
      logic [31:0] now_ms;
      logic        partner_pressed;
      logic [31:0] partner_press_time;
   } req_type;

   // Response word.
   typedef struct packed {
      logic        click_valid;
      logic [31:0] click_time;
      logic [31:0] click_duration;
      logic        click_simultaneous;
      logic [1:0]  click_class;
      logic        pressed;
      logic [31:0] held_duration;
      logic        long_held;
      logic [31:0] release_duration;
      logic [3:0]  available;
      logic        partner_confirm;
   } rsp_type;

   // Control register set.
   typedef struct packed {
      logic [15:0] long_click_time;
      logic [15:0] simultaneous_window;
      logic        simultaneous_responder;
   } cfg_type;

   // One click record in the ring memory.
   typedef struct packed {
      logic [31:0] press_ms;
      logic [31:0] duration;
      logic        simul;
   } ring_entry_type;

endpackage

FILE: src/bcr_csr.sv
// Control registers of the button click recorder.
module bcr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bcr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bcr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output bcr_pkg::cfg_type                cfg
);
   import bcr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken; an index beyond the register list is dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LONG_CLICK: cfg_in.long_click_time = csr_wdata;
            CSR_SIM_WINDOW: cfg_in.simultaneous_window = csr_wdata;
            CSR_SIM_RESP:   cfg_in.simultaneous_responder = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_click_time <= LONG_CLICK_RST;
         cfg_ff.simultaneous_window <= SIM_WINDOW_RST;
         cfg_ff.simultaneous_responder <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/bcr_ring_mem.sv
// Click record memory: one write port and one registered read port.
module bcr_ring_mem #(
   parameter int DEPTH = 8
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output bcr_pkg::ring_entry_type       rd_data,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  bcr_pkg::ring_entry_type       wr_data
);
   import bcr_pkg::*;

   ring_entry_type mem [DEPTH];
   ring_entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/bcr_engine.sv
// Sequencer, ring pointers, press state and response register.
module bcr_engine #(
   parameter int RING_DEPTH = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bcr_pkg::cfg_type                cfg,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bcr_pkg::req_type                req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bcr_pkg::rsp_type                rsp_item,
   output logic                            mem_rd_en,
   output logic [$clog2(RING_DEPTH)-1:0]   mem_rd_addr,
   input  bcr_pkg::ring_entry_type         mem_rd_data,
   output logic                            mem_wr_en,
   output logic [$clog2(RING_DEPTH)-1:0]   mem_wr_addr,
   output bcr_pkg::ring_entry_type         mem_wr_data
);
   import bcr_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   state_type        state_ff, state_in;
   req_type          item_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pressed_ff, pressed_in;
   logic [31:0]      press_time_ff, press_time_in;
   logic             simul_ff, simul_in;
   logic [31:0]      last_end_ff, last_end_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic        req_fire;
   logic        exec_done;
   logic        is_release;
   logic [31:0] held_diff;
   logic [31:0] cur_held;
   logic [31:0] sim_diff;
   logic        sim_hit;
   logic        pop_ok;
   logic [31:0] long_ext;
   logic [31:0] window_ext;

   // One item at a time: accept in idle, finish once the response slot frees.
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign exec_done = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   // The oldest record is fetched on every accept; only a pop uses it.
   assign mem_rd_en   = req_fire;
   assign mem_rd_addr = rd_ptr_ff;

   // Shared differences and compares for the item under work.
   assign long_ext   = {16'd0, cfg.long_click_time};
   assign window_ext = {16'd0, cfg.simultaneous_window};
   assign held_diff  = item_ff.now_ms - press_time_ff;
   assign cur_held   = pressed_ff ? held_diff : 32'd0;
   assign sim_diff   = (item_ff.now_ms >= item_ff.partner_press_time)
                       ? (item_ff.now_ms - item_ff.partner_press_time)
                       : (item_ff.partner_press_time - item_ff.now_ms);
   assign sim_hit    = !simul_ff && item_ff.partner_pressed && (sim_diff < window_ext);
   assign pop_ok     = (count_ff != '0) && (cur_held < long_ext);
   assign is_release = (op_type'(item_ff.opcode) == OP_LEVEL) && !item_ff.level;

   // A release writes a new record at the write pointer.
   assign mem_wr_en   = exec_done && is_release;
   assign mem_wr_addr = wr_ptr_ff;
   always_comb begin
      mem_wr_data.press_ms = press_time_ff;
      mem_wr_data.duration = held_diff;
      mem_wr_data.simul    = simul_ff;
   end

   // Next state of the recorder and the response word for this item.
   always_comb begin
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      count_in      = count_ff;
      pressed_in    = pressed_ff;
      press_time_in = press_time_ff;
      simul_in      = simul_ff;
      last_end_in   = last_end_ff;
      rsp_in        = '0;

      unique case (op_type'(item_ff.opcode))
         OP_LEVEL: begin
            pressed_in = item_ff.level;
            if (item_ff.level) begin
               press_time_in = item_ff.now_ms;
               if (sim_hit) begin
                  simul_in = 1'b1;
                  rsp_in.partner_confirm = 1'b1;
               end
            end else begin
               // Press time plus duration is the release time itself.
               last_end_in   = item_ff.now_ms;
               press_time_in = '0;
               simul_in      = 1'b0;
               wr_ptr_in     = next_ptr(wr_ptr_ff);
               if (count_ff == CNT_FULL) begin
                  rd_ptr_in = next_ptr(rd_ptr_ff);
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         OP_POP: begin
            if (pop_ok) begin
               rsp_in.click_valid        = 1'b1;
               rsp_in.click_time         = mem_rd_data.press_ms;
               rsp_in.click_duration     = mem_rd_data.duration;
               rsp_in.click_simultaneous = mem_rd_data.simul;
               rd_ptr_in = next_ptr(rd_ptr_ff);
               count_in  = count_ff - 1'b1;
               priority if (cfg.simultaneous_responder && mem_rd_data.simul &&
                            (mem_rd_data.duration < long_ext)) begin
                  rsp_in.click_class = CLASS_SIMUL;
               end else if (!mem_rd_data.simul && (mem_rd_data.duration < long_ext)) begin
                  rsp_in.click_class = CLASS_CLICK;
               end else begin
                  rsp_in.click_class = CLASS_IGNORE;
               end
            end else begin
               rsp_in.click_class = CLASS_NONE;
            end
         end
         OP_CONFIRM: begin
            simul_in = 1'b1;
         end
         OP_WIPE: begin
            wr_ptr_in = '0;
            rd_ptr_in = '0;
            count_in  = '0;
         end
         default: begin
            simul_in = simul_ff;
         end
      endcase

      // Live status after the item; a fresh press has held for zero time.
      rsp_in.pressed = pressed_in;
      rsp_in.held_duration =
         (pressed_in && (op_type'(item_ff.opcode) != OP_LEVEL)) ? held_diff : 32'd0;
      rsp_in.long_held = pressed_in && (rsp_in.held_duration >= long_ext);
      rsp_in.release_duration = pressed_in ? 32'd0 : (item_ff.now_ms - last_end_in);
      rsp_in.available = 4'(count_in);
   end

   // Sequencer and response slot control.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_done) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State, recorder registers and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         pressed_ff    <= 1'b0;
         press_time_ff <= '0;
         simul_ff      <= 1'b0;
         last_end_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            item_ff <= req_item;
         end
         if (exec_done) begin
            wr_ptr_ff     <= wr_ptr_in;
            rd_ptr_ff     <= rd_ptr_in;
            count_ff      <= count_in;
            pressed_ff    <= pressed_in;
            press_time_ff <= press_time_in;
            simul_ff      <= simul_in;
            last_end_ff   <= last_end_in;
            rsp_ff        <= rsp_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The fill count never passes the ring depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_FULL)
      else $error("ring fill count above depth");

   // An empty or full ring has its pointers together.
   assert property (@(posedge clock) disable iff (reset)
      ((count_ff == '0) || (count_ff == CNT_FULL)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("ring pointers disagree with fill count");

   // The memory is written only while an item finishes.
   assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == S_EXEC))
      else $error("ring write outside of item execution");

   // An accepted word is worked on in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_EXEC))
      else $error("accepted word not executed");

   // A finished item always leaves a response waiting.
   assert property (@(posedge clock) disable iff (reset)
      exec_done |=> rsp_valid_ff)
      else $error("finished item left no response");

endmodule

FILE: src/button_click_recorder_top.sv
// Top level of the button click recorder.
//
//   Channel   Ports                               Moves
//   request   req_valid/req_ready/req_item         one event word per accept
//   response  rsp_valid/rsp_ready/rsp_item         one result word per request
//   control   csr_valid/csr_ready/csr_index/wdata  one register write per accept
//
// Each request word is handled in an accept cycle, which issues the read of the
// oldest record, and a work cycle, which uses the registered memory data, updates
// the ring and press state and loads the response register.
// A request is accepted while an earlier response still waits; the work cycle
// stalls only while that response has not been taken.
// Reset is synchronous; the ring memory needs no clearing pass since records
// are reached only through the fill count.
module button_click_recorder_top #(
   parameter int RING_DEPTH = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bcr_pkg::req_type                req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bcr_pkg::rsp_type                rsp_item,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bcr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bcr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bcr_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);

   cfg_type          cfg;
   logic             mem_rd_en;
   logic [PTR_W-1:0] mem_rd_addr;
   ring_entry_type   mem_rd_data;
   logic             mem_wr_en;
   logic [PTR_W-1:0] mem_wr_addr;
   ring_entry_type   mem_wr_data;

   // Control registers.
   bcr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Click record memory.
   bcr_ring_mem #(
      .DEPTH (RING_DEPTH)
   ) u_ring_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // Sequencer and recorder state.
   bcr_engine #(
      .RING_DEPTH (RING_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

endmodule

FILE: sim/button_click_recorder_top_tb.sv
// Self-checking testbench of the button click recorder top level.
module button_click_recorder_top_tb;
   import bcr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int MAX_PRINTED = 100;

   // One row of the directed part: a request word and, where it is obvious,
   // the response word typed in.
   typedef struct {
      req_type word;
      bit      fixed;
      rsp_type want;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_item;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_LONG_CLICK;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the recorder state and its registers.
   logic [15:0]  sh_long = LONG_CLICK_RST;
   logic [15:0]  sh_window = SIM_WINDOW_RST;
   logic         sh_resp = 1'b0;
   logic [31:0]  sh_ring_time [RING_DEPTH];
   logic [31:0]  sh_ring_dur [RING_DEPTH];
   logic         sh_ring_simul [RING_DEPTH];
   int unsigned  sh_wr = 0;
   int unsigned  sh_rd = 0;
   int unsigned  sh_fill = 0;
   logic         sh_pressed = 1'b0;
   logic [31:0]  sh_press_time = '0;
   logic         sh_simul_mark = 1'b0;
   logic [31:0]  sh_last_time = '0;
   logic [31:0]  sh_last_dur = '0;

   rsp_type          pending_rsp_words [$];
   directed_row_type directed_rows [25];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;
   int rsp_count = 0;
   int items_sent = 0;
   int settings_used = 0;
   int popped_records = 0;
   int dropped_records = 0;
   int confirm_pulses = 0;
   logic [31:0] cur_ms = '0;

   button_click_recorder_top #(
      .RING_DEPTH(RING_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Free-running clock, 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic req_type mk_req(op_type op, logic lvl, logic [31:0] now,
                                      logic pp, logic [31:0] ppt);
      req_type r;
      r.opcode = op;
      r.level = lvl;
      r.now_ms = now;
      r.partner_pressed = pp;
      r.partner_press_time = ppt;
      return r;
   endfunction

   // Applies one request word to the shadow state and returns the response
   // word that the recorder should give for it.
   function automatic rsp_type predict_rsp_word(req_type w);
      rsp_type     r;
      logic [31:0] diff;
      logic [31:0] cur_held;
      r = '0;
      case (w.opcode)
         OP_LEVEL: begin
            sh_pressed = w.level;
            if (w.level) begin
               sh_press_time = w.now_ms;
               // Plain magnitude of the two stamps, no wrap correction.
               diff = (sh_press_time >= w.partner_press_time) ?
                      sh_press_time - w.partner_press_time :
                      w.partner_press_time - sh_press_time;
               if (!sh_simul_mark && w.partner_pressed && diff < {16'd0, sh_window}) begin
                  sh_simul_mark = 1'b1;
                  r.partner_confirm = 1'b1;
                  confirm_pulses++;
               end
            end else begin
               sh_ring_time[sh_wr] = sh_press_time;
               sh_ring_dur[sh_wr] = w.now_ms - sh_press_time;
               sh_ring_simul[sh_wr] = sh_simul_mark;
               sh_last_time = sh_press_time;
               sh_last_dur = w.now_ms - sh_press_time;
               sh_press_time = '0;
               sh_simul_mark = 1'b0;
               sh_wr = (sh_wr + 1) % RING_DEPTH;
               // A full ring gives up its oldest record.
               if (sh_fill >= RING_DEPTH) begin
                  sh_rd = (sh_rd + 1) % RING_DEPTH;
                  dropped_records++;
               end else begin
                  sh_fill++;
               end
            end
         end
         OP_POP: begin
            cur_held = sh_pressed ? w.now_ms - sh_press_time : 32'd0;
            if (sh_fill > 0 && cur_held < {16'd0, sh_long}) begin
               r.click_valid = 1'b1;
               r.click_time = sh_ring_time[sh_rd];
               r.click_duration = sh_ring_dur[sh_rd];
               r.click_simultaneous = sh_ring_simul[sh_rd];
               sh_rd = (sh_rd + 1) % RING_DEPTH;
               sh_fill--;
               popped_records++;
               if (sh_resp && r.click_simultaneous && r.click_duration < {16'd0, sh_long})
                  r.click_class = CLASS_SIMUL;
               else if (!r.click_simultaneous && r.click_duration < {16'd0, sh_long})
                  r.click_class = CLASS_CLICK;
               else
                  r.click_class = CLASS_IGNORE;
            end
         end
         OP_CONFIRM: begin
            sh_simul_mark = 1'b1;
         end
         default: begin
            sh_wr = 0;
            sh_rd = 0;
            sh_fill = 0;
         end
      endcase
      r.pressed = sh_pressed;
      r.held_duration = sh_pressed ? w.now_ms - sh_press_time : 32'd0;
      r.long_held = sh_pressed && (r.held_duration >= {16'd0, sh_long});
      r.release_duration = sh_pressed ? 32'd0 : w.now_ms - (sh_last_time + sh_last_dur);
      r.available = 4'(sh_fill);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_PRINTED)
         $display("mismatch in response %0d, %s: got %0h, want %0h",
                  rsp_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_result(input rsp_type got, input rsp_type want);
      if (got.click_valid !== want.click_valid)
         report_mismatch("click_valid", 32'(got.click_valid), 32'(want.click_valid));
      if (got.click_time !== want.click_time)
         report_mismatch("click_time", got.click_time, want.click_time);
      if (got.click_duration !== want.click_duration)
         report_mismatch("click_duration", got.click_duration, want.click_duration);
      if (got.click_simultaneous !== want.click_simultaneous)
         report_mismatch("click_simultaneous", 32'(got.click_simultaneous),
                         32'(want.click_simultaneous));
      if (got.click_class !== want.click_class)
         report_mismatch("click_class", 32'(got.click_class), 32'(want.click_class));
      if (got.pressed !== want.pressed)
         report_mismatch("pressed", 32'(got.pressed), 32'(want.pressed));
      if (got.held_duration !== want.held_duration)
         report_mismatch("held_duration", got.held_duration, want.held_duration);
      if (got.long_held !== want.long_held)
         report_mismatch("long_held", 32'(got.long_held), 32'(want.long_held));
      if (got.release_duration !== want.release_duration)
         report_mismatch("release_duration", got.release_duration, want.release_duration);
      if (got.available !== want.available)
         report_mismatch("available", 32'(got.available), 32'(want.available));
      if (got.partner_confirm !== want.partner_confirm)
         report_mismatch("partner_confirm", 32'(got.partner_confirm),
                         32'(want.partner_confirm));
   endtask

   // Response side: check each accepted word and watch for a hung channel.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp_words.size() == 0)
               report_mismatch("word with nothing awaited", 32'(rsp_item.available), 32'd0);
            else
               check_result(rsp_item, pending_rsp_words.pop_front());
            rsp_count++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offers one request word, with random idle cycles ahead of it, and
   // records the awaited response once the word is taken.
   task automatic send_req(input req_type w, input bit fixed = 1'b0,
                           input rsp_type fixed_word = '0);
      rsp_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_item <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = predict_rsp_word(w);
      if (fixed) want = fixed_word;
      pending_rsp_words.push_back(want);
      items_sent++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_LONG_CLICK: sh_long = val;
         CSR_SIM_WINDOW: sh_window = val;
         CSR_SIM_RESP:   sh_resp = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] long_ms, input logic [15:0] window_ms,
                             input logic responder);
      write_csr(CSR_LONG_CLICK, long_ms);
      write_csr(CSR_SIM_WINDOW, window_ms);
      write_csr(CSR_SIM_RESP, {15'd0, responder});
      settings_used++;
   endtask

   // Stops offering words and waits until every response has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One press and release, with an optional confirm ahead of the press and optional
   // pops, confirms and a repeated press while the button is held.
   task automatic send_click();
      logic [31:0] t_press;
      logic [31:0] hold;
      logic [31:0] ppt;
      logic [31:0] w;
      logic        pp;
      w = {16'd0, sh_window};
      cur_ms = cur_ms + 32'($urandom_range(0, 400));
      t_press = cur_ms;
      pp = ($urandom_range(99) < 70);
      case ($urandom_range(3))
         0: ppt = t_press + 32'($urandom_range(0, 2 * w + 4)) - (w + 32'd2);
         1: ppt = $urandom;
         2: ppt = $urandom_range(1) ? t_press + w : t_press - w;
         default: ppt = $urandom_range(1) ? t_press + w - 32'd1 : t_press - w + 32'd1;
      endcase
      if (sh_long == 16'd0 || $urandom_range(99) < 30)
         hold = {16'd0, sh_long} + 32'($urandom_range(0, 500));
      else
         hold = 32'($urandom_range(0, sh_long - 1));
      if ($urandom_range(99) < 8)
         send_req(mk_req(OP_CONFIRM, 1'($urandom), t_press, 1'($urandom), $urandom));
      send_req(mk_req(OP_LEVEL, 1'b1, t_press, pp, ppt));
      if ($urandom_range(99) < 6) begin
         t_press = t_press + 32'($urandom_range(0, 50));
         send_req(mk_req(OP_LEVEL, 1'b1, t_press, pp, ppt + 32'($urandom_range(0, 20))));
      end
      if ($urandom_range(99) < 30)
         send_req(mk_req(OP_POP, 1'($urandom), t_press + 32'($urandom_range(0, hold)),
                         1'($urandom), $urandom));
      if ($urandom_range(99) < 10)
         send_req(mk_req(OP_CONFIRM, 1'($urandom), t_press, 1'($urandom), $urandom));
      cur_ms = t_press + hold;
      send_req(mk_req(OP_LEVEL, 1'b0, cur_ms, 1'($urandom), $urandom));
   endtask

   // Mostly well-formed clicks with pops in between; the rest is wipes,
   // confirms, stray releases, time jumps and fully random words.
   task automatic run_traffic(input int n_items);
      int start;
      int pick;
      start = items_sent;
      while (items_sent - start < n_items) begin
         pick = $urandom_range(99);
         if (pick < 50)
            send_click();
         else if (pick < 72)
            send_req(mk_req(OP_POP, 1'($urandom), cur_ms + 32'($urandom_range(0, 300)),
                            1'($urandom), $urandom));
         else if (pick < 77)
            send_req(mk_req(OP_CONFIRM, 1'($urandom), cur_ms, 1'($urandom), $urandom));
         else if (pick < 80)
            send_req(mk_req(OP_WIPE, 1'($urandom), cur_ms, 1'($urandom), $urandom));
         else if (pick < 84)
            send_req(mk_req(OP_LEVEL, 1'b0, cur_ms + 32'($urandom_range(0, 900)),
                            1'($urandom), $urandom));
         else if (pick < 88)
            cur_ms = $urandom;
         else
            send_req(mk_req(op_type'($urandom_range(3)), 1'($urandom), $urandom,
                            1'($urandom), $urandom));
      end
   endtask

   // Main sequence: reset, directed rows, then random phases.
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows at the reset register values.
      directed_rows[0]  = '{mk_req(OP_POP, 1'b0, 32'd500, 1'b0, 32'd0), 1'b1,
         '{1'b0, 32'd0, 32'd0, 1'b0, CLASS_NONE, 1'b0, 32'd0, 1'b0, 32'd500, 4'd0, 1'b0}};
      directed_rows[1]  = '{mk_req(OP_LEVEL, 1'b1, 32'd1000, 1'b0, 32'd0), 1'b1,
         '{1'b0, 32'd0, 32'd0, 1'b0, CLASS_NONE, 1'b1, 32'd0, 1'b0, 32'd0, 4'd0, 1'b0}};
      directed_rows[2]  = '{mk_req(OP_LEVEL, 1'b0, 32'd1300, 1'b0, 32'd0), 1'b1,
         '{1'b0, 32'd0, 32'd0, 1'b0, CLASS_NONE, 1'b0, 32'd0, 1'b0, 32'd0, 4'd1, 1'b0}};
      directed_rows[3]  = '{mk_req(OP_POP, 1'b0, 32'd1400, 1'b0, 32'd0), 1'b1,
         '{1'b1, 32'd1000, 32'd300, 1'b0, CLASS_CLICK, 1'b0, 32'd0, 1'b0, 32'd100,
           4'd0, 1'b0}};
      // Press within the window of a pressed partner, then a repeated press.
      directed_rows[4]  = '{mk_req(OP_LEVEL, 1'b1, 32'd2000, 1'b1, 32'd1950), 1'b0, '0};
      directed_rows[5]  = '{mk_req(OP_LEVEL, 1'b1, 32'd2010, 1'b1, 32'd2000), 1'b0, '0};
      directed_rows[6]  = '{mk_req(OP_LEVEL, 1'b0, 32'd2100, 1'b0, 32'd0), 1'b0, '0};
      directed_rows[7]  = '{mk_req(OP_POP, 1'b1, 32'd2200, 1'b1, 32'd5), 1'b0, '0};
      // Difference equal to the window, then one below it from the other side.
      directed_rows[8]  = '{mk_req(OP_LEVEL, 1'b1, 32'd3000, 1'b1, 32'd3100), 1'b0, '0};
      directed_rows[9]  = '{mk_req(OP_LEVEL, 1'b1, 32'd3000, 1'b1, 32'd2901), 1'b0, '0};
      directed_rows[10] = '{mk_req(OP_LEVEL, 1'b0, 32'd5000, 1'b0, 32'd0), 1'b0, '0};
      // A pop is refused while the button is held long.
      directed_rows[11] = '{mk_req(OP_LEVEL, 1'b1, 32'd6000, 1'b0, 32'd0), 1'b0, '0};
      directed_rows[12] = '{mk_req(OP_POP, 1'b0, 32'd7500, 1'b0, 32'd0), 1'b0, '0};
      directed_rows[13] = '{mk_req(OP_POP, 1'b0, 32'd6500, 1'b0, 32'd0), 1'b0, '0};
      // Release twice, then confirm while released.
      directed_rows[14] = '{mk_req(OP_LEVEL, 1'b0, 32'd6600, 1'b0, 32'd0), 1'b0, '0};
      directed_rows[15] = '{mk_req(OP_LEVEL, 1'b0, 32'd6700, 1'b1, 32'd6700), 1'b0, '0};
      directed_rows[16] = '{mk_req(OP_CONFIRM, 1'b1, 32'd6800, 1'b1, 32'hFFFF_FFFF),
                            1'b0, '0};
      directed_rows[17] = '{mk_req(OP_LEVEL, 1'b1, 32'd7000, 1'b1, 32'd7000), 1'b0, '0};
      directed_rows[18] = '{mk_req(OP_LEVEL, 1'b0, 32'd7100, 1'b0, 32'd0), 1'b0, '0};
      // Wipe keeps the press state and the last click.
      directed_rows[19] = '{mk_req(OP_WIPE, 1'b1, 32'd7200, 1'b1, 32'd0), 1'b0, '0};
      directed_rows[20] = '{mk_req(OP_POP, 1'b0, 32'd7300, 1'b0, 32'd0), 1'b0, '0};
      // Stamps at the ends of the range; the duration wraps.
      directed_rows[21] = '{mk_req(OP_LEVEL, 1'b1, 32'hFFFF_FFF0, 1'b1, 32'hFFFF_FFFF),
                            1'b0, '0};
      directed_rows[22] = '{mk_req(OP_LEVEL, 1'b0, 32'h0000_0010, 1'b1, 32'hFFFF_FFFF),
                            1'b0, '0};
      directed_rows[23] = '{mk_req(OP_POP, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'd0), 1'b0, '0};
      // Stamps near zero and near the top are far apart: no wrap correction.
      directed_rows[24] = '{mk_req(OP_LEVEL, 1'b1, 32'd0, 1'b1, 32'hFFFF_FFFF), 1'b0, '0};

      foreach (directed_rows[i])
         send_req(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].want);
      wait_idle();

      // Responder on, no idling on either side.
      set_config(16'd1000, 16'd100, 1'b1);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_traffic(240);
      wait_idle();

      // Smallest window and a long click time of one, sender mostly idle.
      set_config(16'd1, 16'd0, 1'b0);
      send_idle_pct = 78;
      rsp_stall_pct = 0;
      run_traffic(240);
      wait_idle();

      // Largest settings, receiver mostly stalled.
      set_config(16'hFFFF, 16'hFFFF, 1'b1);
      send_idle_pct = 0;
      rsp_stall_pct = 78;
      run_traffic(240);
      wait_idle();

      // Light idling on both sides, with one long receiver hold-off.
      set_config(16'd300, 16'd50, 1'b1);
      send_idle_pct = 6;
      rsp_stall_pct = 6;
      run_traffic(120);
      hold_token++;
      run_traffic(120);
      wait_idle();

      // Zero long click time: every held press counts long.
      set_config(16'd0, 16'd20, 1'b1);
      send_idle_pct = 78;
      rsp_stall_pct = 0;
      run_traffic(200);
      wait_idle();

      // Random settings, mostly modest ones.
      for (int p = 0; p < 2; p++) begin
         set_config(16'($urandom_range(1, 3000)), 16'($urandom_range(0, 400)),
                    1'($urandom));
         send_idle_pct = p * 78;
         rsp_stall_pct = (1 - p) * 78;
         run_traffic(120);
         wait_idle();
      end

      $display("Ran %0d request words over %0d register settings and the reset values.",
               items_sent, settings_used);
      $display("Popped %0d records, dropped %0d on a full ring, sent %0d confirm pulses.",
               popped_records, dropped_records, confirm_pulses);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: sim.f
src/bcr_pkg.sv
src/bcr_csr.sv
src/bcr_ring_mem.sv
src/bcr_engine.sv
src/button_click_recorder_top.sv
sim/button_click_recorder_top_tb.sv
